// ----- rtl/core/scc_pkg.sv -----
package scc_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 4096;
    localparam int NODE_W    = 10;
    localparam int EDGE_AW   = 12;
    localparam int LINK_W    = 13;
    localparam int CNT_W     = 11;
    localparam int PAIR_W    = 19;
    localparam int TOTAL_W   = 20;

    localparam logic [LINK_W-1:0] LIST_END = LINK_W'(MAX_EDGES);

    typedef struct packed {
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] tgt;
        logic [LINK_W-1:0] flink;
        logic [LINK_W-1:0] rlink;
    } edge_entry_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [LINK_W-1:0] cursor;
    } stack_entry_t;

endpackage

// ----- rtl/core/scc_ram.sv -----
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/strongly_connected_pair_count.sv -----
// edge item: accepted in S_IDLE, then linked into the forward and reverse head lists in S_INS
// finish item: a forward pass scans each node, walks its edges and pops finished nodes, then
//   the visited flags are swept before the reverse pass, which sums pairs per component; then the result is registered
// after the result the head lists and visited flags are swept, no items taken
// the walk is bound by the single read port of the edge, head and stack memories
// reset: the same sweep runs before the first item is accepted; node_count resets to 1
module strongly_connected_pair_count (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // edge_from, edge_to, zero pad
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // pair_count, edges_dropped, zero pad
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_INS    = 4'd2;
    localparam logic [3:0] S_FSCAN  = 4'd3;
    localparam logic [3:0] S_START  = 4'd4;
    localparam logic [3:0] S_EDGE   = 4'd5;
    localparam logic [3:0] S_EDGE2  = 4'd6;
    localparam logic [3:0] S_VIS    = 4'd7;
    localparam logic [3:0] S_POP    = 4'd8;
    localparam logic [3:0] S_VCLR   = 4'd9;
    localparam logic [3:0] S_RSCAN  = 4'd10;
    localparam logic [3:0] S_RSCAN2 = 4'd11;
    localparam logic [3:0] S_ACC    = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    localparam int NW = scc_pkg::NODE_W;
    localparam int LW = scc_pkg::LINK_W;
    localparam int CW = scc_pkg::CNT_W;
    localparam int EW = scc_pkg::EDGE_AW;
    localparam int TW = scc_pkg::TOTAL_W;
    localparam int PW = scc_pkg::PAIR_W;
    localparam logic [CW-1:0] NODE_CAP = CW'(scc_pkg::MAX_NODES);
    localparam logic [NW-1:0] SWEEP_LAST = '1;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] node_count_reg;
    logic [NW-1:0] clr_reg, clr_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] fin_reg, fin_next;
    logic [CW-1:0] depth_reg, depth_next;
    logic [NW-1:0] top_node_reg, top_node_next;
    logic [LW-1:0] top_cur_reg, top_cur_next;
    logic [NW-1:0] t_reg, t_next;
    logic [NW-1:0] node_reg, node_next;
    logic [CW-1:0] comp_reg, comp_next;
    logic [TW-1:0] pair_reg, pair_next;
    logic [LW-1:0] edge_total_reg, edge_total_next;
    logic          ovf_reg, ovf_next;
    logic          rev_reg, rev_next;
    logic [NW-1:0] a_reg, a_next;
    logic [NW-1:0] b_reg, b_next;
    logic          out_valid_reg, out_valid_next;
    logic [TW-1:0] out_data_reg, out_data_next;

    logic [CW-1:0] n_eff;
    logic [2*CW-1:0] prod;
    logic          in_acc;

    logic                 em_we;
    logic [EW-1:0]        em_waddr, em_raddr;
    scc_pkg::edge_entry_t em_wdata, em_rd;
    logic                 fh_we, rh_we;
    logic [NW-1:0]        fh_waddr, rh_waddr, fh_raddr, rh_raddr, head_raddr;
    logic [LW-1:0]        fh_wdata, rh_wdata, fh_rd, rh_rd, head_rd;
    logic                 vis_we, vis_wdata, vis_rd;
    logic [NW-1:0]        vis_waddr, vis_raddr;
    logic                 fin_we;
    logic [NW-1:0]        fin_waddr, fin_raddr, fin_wdata, fin_rd;
    logic                  stk_we;
    logic [NW-1:0]         stk_waddr, stk_raddr;
    scc_pkg::stack_entry_t stk_wdata, stk_rd;
    logic [NW-1:0]        walk_t;
    logic [LW-1:0]        walk_link;

    scc_ram #(.WIDTH($bits(scc_pkg::edge_entry_t)), .DEPTH(scc_pkg::MAX_EDGES)) u_edge_mem (
        .clk(clk), .we(em_we), .waddr(em_waddr), .wdata(em_wdata),
        .raddr(em_raddr), .rdata(em_rd)
    );
    scc_ram #(.WIDTH(LW), .DEPTH(scc_pkg::MAX_NODES)) u_fhead_mem (
        .clk(clk), .we(fh_we), .waddr(fh_waddr), .wdata(fh_wdata),
        .raddr(fh_raddr), .rdata(fh_rd)
    );
    scc_ram #(.WIDTH(LW), .DEPTH(scc_pkg::MAX_NODES)) u_rhead_mem (
        .clk(clk), .we(rh_we), .waddr(rh_waddr), .wdata(rh_wdata),
        .raddr(rh_raddr), .rdata(rh_rd)
    );
    scc_ram #(.WIDTH(1), .DEPTH(scc_pkg::MAX_NODES)) u_vis_mem (
        .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
        .raddr(vis_raddr), .rdata(vis_rd)
    );
    scc_ram #(.WIDTH(NW), .DEPTH(scc_pkg::MAX_NODES)) u_fin_mem (
        .clk(clk), .we(fin_we), .waddr(fin_waddr), .wdata(fin_wdata),
        .raddr(fin_raddr), .rdata(fin_rd)
    );
    scc_ram #(.WIDTH($bits(scc_pkg::stack_entry_t)), .DEPTH(scc_pkg::MAX_NODES)) u_stk_mem (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rd)
    );

    assign n_eff    = (node_count_reg > NODE_CAP) ? NODE_CAP : node_count_reg;
    assign prod     = comp_reg * (comp_reg - CW'(1));
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign head_rd  = rev_reg ? rh_rd : fh_rd;
    assign walk_t   = rev_reg ? em_rd.src : em_rd.tgt;
    assign walk_link = rev_reg ? em_rd.rlink : em_rd.flink;
    assign fh_raddr = (state_reg == S_IDLE) ? s_axis_tdata[9:0] : head_raddr;
    assign rh_raddr = (state_reg == S_IDLE) ? s_axis_tdata[19:10] : head_raddr;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_data_reg};

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        i_next          = i_reg;
        fin_next        = fin_reg;
        depth_next      = depth_reg;
        top_node_next   = top_node_reg;
        top_cur_next    = top_cur_reg;
        t_next          = t_reg;
        node_next       = node_reg;
        comp_next       = comp_reg;
        pair_next       = pair_reg;
        edge_total_next = edge_total_reg;
        ovf_next        = ovf_reg;
        rev_next        = rev_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        em_we      = 1'b0;
        em_waddr   = edge_total_reg[EW-1:0];
        em_wdata   = '{src: a_reg, tgt: b_reg, flink: fh_rd, rlink: rh_rd};
        em_raddr   = top_cur_reg[EW-1:0];
        fh_we      = 1'b0;
        fh_waddr   = a_reg;
        fh_wdata   = edge_total_reg;
        rh_we      = 1'b0;
        rh_waddr   = b_reg;
        rh_wdata   = edge_total_reg;
        head_raddr = walk_t;
        vis_we     = 1'b0;
        vis_waddr  = clr_reg;
        vis_wdata  = 1'b0;
        vis_raddr  = walk_t;
        fin_we     = 1'b0;
        fin_waddr  = fin_reg[NW-1:0];
        fin_wdata  = top_node_reg;
        fin_raddr  = fin_reg[NW-1:0] - NW'(1);
        stk_we     = 1'b0;
        stk_waddr  = depth_reg[NW-1:0] - NW'(1);
        stk_wdata  = '{node: top_node_reg, cursor: top_cur_reg};
        stk_raddr  = depth_reg[NW-1:0] - NW'(2);

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                fh_we     = 1'b1;
                fh_waddr  = clr_reg;
                fh_wdata  = scc_pkg::LIST_END;
                rh_we     = 1'b1;
                rh_waddr  = clr_reg;
                rh_wdata  = scc_pkg::LIST_END;
                vis_we    = 1'b1;
                clr_next  = clr_reg + NW'(1);
                if (clr_reg == SWEEP_LAST)
                begin
                    edge_total_next = '0;
                    ovf_next        = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (!s_axis_tuser)
                    begin
                        if (edge_total_reg >= scc_pkg::LIST_END)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            a_next     = s_axis_tdata[9:0];
                            b_next     = s_axis_tdata[19:10];
                            state_next = S_INS;
                        end
                    end
                    else
                    begin
                        i_next     = '0;
                        fin_next   = '0;
                        pair_next  = '0;
                        rev_next   = 1'b0;
                        state_next = S_FSCAN;
                    end
                end
            end
            S_INS:
            begin
                em_we           = 1'b1;
                fh_we           = 1'b1;
                rh_we           = 1'b1;
                edge_total_next = edge_total_reg + LW'(1);
                state_next      = S_IDLE;
            end
            S_FSCAN:
            begin
                if (i_reg >= n_eff)
                begin
                    clr_next   = '0;
                    state_next = S_VCLR;
                end
                else
                begin
                    node_next  = i_reg[NW-1:0];
                    vis_raddr  = i_reg[NW-1:0];
                    head_raddr = i_reg[NW-1:0];
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (vis_rd)
                begin
                    if (rev_reg)
                    begin
                        fin_next   = fin_reg - CW'(1);
                        state_next = S_RSCAN;
                    end
                    else
                    begin
                        i_next     = i_reg + CW'(1);
                        state_next = S_FSCAN;
                    end
                end
                else
                begin
                    vis_we        = 1'b1;
                    vis_waddr     = node_reg;
                    vis_wdata     = 1'b1;
                    top_node_next = node_reg;
                    top_cur_next  = head_rd;
                    depth_next    = CW'(1);
                    comp_next     = CW'(1);
                    state_next    = S_EDGE;
                end
            end
            S_EDGE:
            begin
                if (top_cur_reg >= scc_pkg::LIST_END)
                begin
                    if (!rev_reg && !fin_reg[CW-1])
                    begin
                        fin_we   = 1'b1;
                        fin_next = fin_reg + CW'(1);
                    end
                    depth_next = depth_reg - CW'(1);
                    if (depth_reg == CW'(1))
                    begin
                        if (rev_reg)
                        begin
                            state_next = S_ACC;
                        end
                        else
                        begin
                            i_next     = i_reg + CW'(1);
                            state_next = S_FSCAN;
                        end
                    end
                    else
                    begin
                        state_next = S_POP;
                    end
                end
                else
                begin
                    state_next = S_EDGE2;
                end
            end
            S_EDGE2:
            begin
                top_cur_next = walk_link;
                t_next       = walk_t;
                if ({1'b0, walk_t} >= n_eff)
                begin
                    state_next = S_EDGE;
                end
                else
                begin
                    state_next = S_VIS;
                end
            end
            S_VIS:
            begin
                if (vis_rd || depth_reg >= NODE_CAP)
                begin
                    state_next = S_EDGE;
                end
                else
                begin
                    vis_we        = 1'b1;
                    vis_waddr     = t_reg;
                    vis_wdata     = 1'b1;
                    comp_next     = comp_reg + CW'(1);
                    stk_we        = 1'b1;
                    top_node_next = t_reg;
                    top_cur_next  = head_rd;
                    depth_next    = depth_reg + CW'(1);
                    state_next    = S_EDGE;
                end
            end
            S_POP:
            begin
                top_node_next = stk_rd.node;
                top_cur_next  = stk_rd.cursor;
                state_next    = S_EDGE;
            end
            S_VCLR:
            begin
                vis_we   = 1'b1;
                clr_next = clr_reg + NW'(1);
                if (clr_reg == SWEEP_LAST)
                begin
                    rev_next   = 1'b1;
                    state_next = S_RSCAN;
                end
            end
            S_RSCAN:
            begin
                if (fin_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_RSCAN2;
                end
            end
            S_RSCAN2:
            begin
                node_next  = fin_rd;
                vis_raddr  = fin_rd;
                head_raddr = fin_rd;
                state_next = S_START;
            end
            S_ACC:
            begin
                pair_next  = pair_reg + TW'(prod >> 1);
                fin_next   = fin_reg - CW'(1);
                state_next = S_RSCAN;
            end
            S_OUT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {ovf_reg, pair_reg[PW-1:0]};
                    clr_next       = '0;
                    state_next     = S_CLEAR;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            node_count_reg <= CW'(1);
            edge_total_reg <= '0;
            ovf_reg        <= 1'b0;
            rev_reg        <= 1'b0;
            depth_reg      <= '0;
            i_reg          <= '0;
            fin_reg        <= '0;
            comp_reg       <= '0;
            pair_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            edge_total_reg <= edge_total_next;
            ovf_reg        <= ovf_next;
            rev_reg        <= rev_next;
            depth_reg      <= depth_next;
            i_reg          <= i_next;
            fin_reg        <= fin_next;
            comp_reg       <= comp_next;
            pair_reg       <= pair_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_node_reg <= top_node_next;
        top_cur_reg  <= top_cur_next;
        t_reg        <= t_next;
        node_reg     <= node_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        out_data_reg <= out_data_next;
    end

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= NODE_CAP)
        else $error("walk stack deeper than node capacity");

    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        edge_total_reg <= scc_pkg::LIST_END)
        else $error("edge count beyond edge store");

    a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside final state");

    a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VIS || state_reg == S_POP) |-> depth_reg != '0)
        else $error("stack access with empty walk");

    a_clear_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !out_valid_reg) |=> state_reg == S_CLEAR)
        else $error("graph store not swept after result");

endmodule
